[design/tgms_pkg.sv]
// shared types and the lane-wise averaging function of the grid subdivider
package tgms_pkg;

    localparam int COORD_W = 24;
    localparam int TDATA_IN_W = 72;
    localparam int TDATA_OUT_W = 80;

    // x in the lowest bits, matching the stream packing
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vtx;

    // floor((a+b)/2) per lane, never overflows 24 bits
    function automatic t_vtx avg_vtx(input t_vtx a, input t_vtx b);
        logic signed [COORD_W:0] sx;
        logic signed [COORD_W:0] sy;
        logic signed [COORD_W:0] sz;
        t_vtx r;
        sx = {a.x[COORD_W-1], a.x} + {b.x[COORD_W-1], b.x};
        sy = {a.y[COORD_W-1], a.y} + {b.y[COORD_W-1], b.y};
        sz = {a.z[COORD_W-1], a.z} + {b.z[COORD_W-1], b.z};
        r.x = sx[COORD_W:1];
        r.y = sy[COORD_W:1];
        r.z = sz[COORD_W:1];
        return r;
    endfunction

endpackage

[design/tgms_ram.sv]
// generic single-write, single-read ram with registered read data
module tgms_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/triangle_grid_midpoint_subdivider_core.sv]
// top level: triangle grid midpoint subdivider with one shared averager
//
// Vertices of a triangular grid arrive base row first, each row one shorter than the last,
// with s_axis_tlast on the last vertex of a row; the grid ends with a one-vertex tip. Both
// row buffers live in one ram as two banks that swap roles when a row completes, so no copy
// is made. A vertex without tlast is taken while idle and gives no output. A vertex with
// tlast starts the sequencer, which reads the ram one entry at a time and feeds a single
// three-lane averager; the old-row and new-row passes are both limited by the single ram
// read port and the shared averager, and slow further if the output side stalls.
// s_axis_tready is low while a row is being emitted. A malformed row gives one transfer with
// tuser set and tlast set, and the grid is dropped. No clearing pass is needed after reset.
module triangle_grid_midpoint_subdivider_core #(
    parameter int MAX_EDGE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // x_coord[23:0], y_coord[47:24], z_coord[71:48]
    input  logic [tgms_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_x[23:0], out_y[47:24], out_z[71:48], out_row_end[72], zero[79:73]
    output logic [tgms_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    // bad_shape[0]
    output logic                          m_axis_tuser
);

    import tgms_pkg::*;

    localparam int IW = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
    localparam int CW = $clog2(MAX_EDGE + 1);
    localparam int AW = IW + 1;
    localparam int VW = 3 * COORD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_NR_RA,
        S_NR_CA,
        S_NR_RU,
        S_NR_RB,
        S_NR_CB,
        S_NR_AVG,
        S_NR_EVEN,
        S_NR_ODD,
        S_OR_RA,
        S_OR_CA,
        S_OR_VTX,
        S_OR_RB,
        S_OR_CB,
        S_OR_MID
    } t_state;

    t_state        r_state;
    logic          r_bank;      // bank of the row being received
    logic [CW-1:0] r_low_len;
    logic [CW-1:0] r_fill;
    logic [IW-1:0] r_k;
    t_vtx          r_a;
    t_vtx          r_b;
    t_vtx          r_u;
    t_vtx          r_mid;

    logic          r_out_valid;
    t_vtx          r_out_vtx;
    logic          r_out_re;
    logic          r_out_last;
    logic          r_out_bad;

    logic          out_free;
    logic          out_load;
    logic          in_xfer;
    logic          limit_hit;
    logic          k_last;
    logic [IW-1:0] k_next;
    logic [CW-1:0] fill_inc;
    logic [AW-1:0] ram_raddr;
    logic [VW-1:0] ram_rdata;
    t_vtx          rd_vtx;
    t_vtx          avg_a;
    t_vtx          avg_b;
    t_vtx          avg_r;

    assign out_free  = !r_out_valid || m_axis_tready;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign fill_inc  = r_fill + CW'(1);
    assign k_next    = r_k + IW'(1);
    assign k_last    = (CW'(r_k) + CW'(1)) == r_fill;
    assign limit_hit = (r_low_len != '0) ? (r_fill >= r_low_len - CW'(1))
                                         : (r_fill >= CW'(MAX_EDGE));
    assign rd_vtx    = t_vtx'(ram_rdata);

    // output register loads in the emitting states once it is free
    always_comb begin
        unique case (r_state)
            S_ERR, S_NR_EVEN, S_NR_ODD, S_OR_VTX, S_OR_MID: out_load = out_free;
            default: out_load = 1'b0;
        endcase
    end

    // read address: lower row sits in the bank opposite the receiving one
    always_comb begin
        unique case (r_state)
            S_NR_RA: ram_raddr = {~r_bank, r_k};
            S_NR_RB: ram_raddr = {~r_bank, k_next};
            S_OR_RB: ram_raddr = {r_bank, k_next};
            default: ram_raddr = {r_bank, r_k};
        endcase
    end

    // operand selection for the shared averager
    always_comb begin
        unique case (r_state)
            S_NR_EVEN: begin
                avg_a = r_a;
                avg_b = '{z: r_u.z, y: r_u.y, x: r_mid.x};
            end
            S_NR_ODD: begin
                avg_a = r_b;
                avg_b = '{z: r_u.z, y: r_u.y, x: r_mid.x};
            end
            default: begin
                avg_a = r_a;
                avg_b = r_b;
            end
        endcase
        avg_r = avg_vtx(avg_a, avg_b);
    end

    tgms_ram #(
        .WIDTH (VW),
        .DEPTH (2 ** AW)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && !limit_hit),
        .i_waddr ({r_bank, r_fill[IW-1:0]}),
        .i_wdata (s_axis_tdata[VW-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_low_len   <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_k <= '0;
                        if (limit_hit) begin
                            r_low_len <= '0;
                            r_fill    <= '0;
                            r_state   <= S_ERR;
                        end else if (!s_axis_tlast) begin
                            r_fill <= fill_inc;
                        end else if (r_low_len != '0 && fill_inc + CW'(1) != r_low_len) begin
                            r_low_len <= '0;
                            r_fill    <= '0;
                            r_state   <= S_ERR;
                        end else begin
                            r_fill  <= fill_inc;
                            r_state <= (r_low_len != '0) ? S_NR_RA : S_OR_RA;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_out_vtx   <= '0;
                        r_out_re    <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_out_bad   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_NR_RA: r_state <= S_NR_CA;
                S_NR_CA: begin
                    r_a     <= rd_vtx;
                    r_state <= S_NR_RU;
                end
                S_NR_RU: r_state <= S_NR_RB;
                S_NR_RB: begin
                    r_u     <= rd_vtx;
                    r_state <= S_NR_CB;
                end
                S_NR_CB: begin
                    r_b     <= rd_vtx;
                    r_state <= S_NR_AVG;
                end
                S_NR_AVG: begin
                    r_mid   <= avg_r;
                    r_state <= S_NR_EVEN;
                end
                S_NR_EVEN: begin
                    if (out_free) begin
                        r_out_vtx   <= avg_r;
                        r_out_re    <= 1'b0;
                        r_out_last  <= 1'b0;
                        r_out_bad   <= 1'b0;
                        r_state     <= S_NR_ODD;
                    end
                end
                S_NR_ODD: begin
                    if (out_free) begin
                        r_out_vtx   <= avg_r;
                        r_out_re    <= k_last;
                        r_out_last  <= 1'b0;
                        r_out_bad   <= 1'b0;
                        if (k_last) begin
                            r_k     <= '0;
                            r_state <= S_OR_RA;
                        end else begin
                            r_a     <= r_b;
                            r_k     <= k_next;
                            r_state <= S_NR_RU;
                        end
                    end
                end
                S_OR_RA: r_state <= S_OR_CA;
                S_OR_CA: begin
                    r_a     <= rd_vtx;
                    r_state <= S_OR_VTX;
                end
                S_OR_VTX: begin
                    if (out_free) begin
                        r_out_vtx   <= r_a;
                        r_out_re    <= k_last;
                        r_out_last  <= k_last;
                        r_out_bad   <= 1'b0;
                        if (k_last) begin
                            // the received row becomes the lower row unless it was the tip
                            if (r_fill > CW'(1)) begin
                                r_low_len <= r_fill;
                                r_bank    <= ~r_bank;
                            end else begin
                                r_low_len <= '0;
                            end
                            r_fill  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_OR_RB;
                        end
                    end
                end
                S_OR_RB: r_state <= S_OR_CB;
                S_OR_CB: begin
                    r_b     <= rd_vtx;
                    r_state <= S_OR_MID;
                end
                S_OR_MID: begin
                    if (out_free) begin
                        r_out_vtx   <= '{z: avg_r.z, y: r_a.y, x: avg_r.x};
                        r_out_re    <= 1'b0;
                        r_out_last  <= 1'b0;
                        r_out_bad   <= 1'b0;
                        r_a         <= r_b;
                        r_k         <= k_next;
                        r_state     <= S_OR_VTX;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_OUT_W - VW - 1){1'b0}}, r_out_re, r_out_vtx};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_bad;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_EDGE))
        else $error("row fill count above the row buffer depth");

    a_no_single_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_len != CW'(1))
        else $error("a one-vertex row was kept as the lower row");

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("error transfer is not a lone zero transfer");

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata[VW])
        else $error("last transfer of a row run does not end an output row");

    a_busy_after_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken again right after a row end");
`endif

endmodule
